### hdl/lgrs_pkg.sv
// shared types, constants and the life rule for the row stencil
package lgrs_pkg;

	localparam int COLS    = 64;
	localparam int WIDTH_W = 7;

	localparam logic [WIDTH_W-1:0] BOARD_WIDTH_RESET = 7'd32;

	typedef logic [COLS-1:0] row_t;

	typedef struct packed {
		row_t row_cells;
		logic last_row;
	} in_t;

	typedef struct packed {
		row_t next_row_cells;
		logic last_of_board;
	} out_t;

	typedef struct packed {
		row_t up;
		row_t mid;
		row_t down;
		logic has_first;
		logic last;
	} job_t;

	function automatic row_t next_gen(input row_t up, input row_t mid, input row_t down);
		logic [COLS+1:0] u;
		logic [COLS+1:0] m;
		logic [COLS+1:0] d;
		logic [3:0]      n;
		row_t            res;
		u = {1'b0, up, 1'b0};
		m = {1'b0, mid, 1'b0};
		d = {1'b0, down, 1'b0};
		for (int k = 0; k < COLS; k++) begin
			n = 4'(u[k]) + 4'(u[k+1]) + 4'(u[k+2])
			  + 4'(m[k]) + 4'(m[k+2])
			  + 4'(d[k]) + 4'(d[k+1]) + 4'(d[k+2]);
			res[k] = (n == 4'd3) || (m[k+1] && (n == 4'd2));
		end
		return res;
	endfunction

endpackage

### hdl/lgrs_front.sv
// front end: line stores and job classification for each incoming row
module lgrs_front
	import lgrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic row_valid,
	output logic row_ready,
	input  in_t  row_data,
	input  row_t col_mask,
	output logic push,
	output job_t push_job,
	input  logic push_ready,
	output logic held
);

	row_t above_q;
	row_t mid_q;
	logic held_q;
	logic accept;
	row_t row_in;

	assign row_ready = push_ready;
	assign accept    = row_valid && push_ready;
	assign row_in    = row_data.row_cells & col_mask;
	assign held      = held_q;

	// a row yields work only when a row is held or it closes the board
	assign push = accept && (held_q || row_data.last_row);

	always_comb begin
		push_job.up        = above_q;
		push_job.mid       = mid_q;
		push_job.down      = row_in;
		push_job.has_first = held_q;
		push_job.last      = row_data.last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= '0;
			mid_q   <= '0;
			held_q  <= 1'b0;
		end else if (accept) begin
			if (row_data.last_row) begin
				above_q <= '0;
				mid_q   <= '0;
				held_q  <= 1'b0;
			end else begin
				above_q <= held_q ? mid_q : '0;
				mid_q   <= row_in;
				held_q  <= 1'b1;
			end
		end
	end

endmodule

### hdl/lgrs_queue.sv
// two-entry job queue between front and back
module lgrs_queue
	import lgrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic push_ready,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hdl/lgrs_back.sv
// back end: next generation of one row per cycle into the output register, while that register is empty or being taken
module lgrs_back
	import lgrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  job_t head_job,
	output logic pop,
	input  row_t col_mask,
	output logic res_valid,
	input  logic res_ready,
	output out_t res_data
);

	logic phase_q;
	logic res_valid_q;
	out_t res_q;
	logic emit;
	logic sel_second;
	logic done_entry;
	row_t up_sel;
	row_t mid_sel;
	row_t down_sel;

	assign sel_second = !head_job.has_first || phase_q;
	assign done_entry = sel_second || !head_job.last;
	assign emit       = head_valid && (!res_valid_q || res_ready);
	assign pop        = emit && done_entry;

	// second result of a last row: its own generation with a dead row below
	always_comb begin
		if (sel_second) begin
			up_sel   = head_job.has_first ? head_job.mid : '0;
			mid_sel  = head_job.down;
			down_sel = '0;
		end else begin
			up_sel   = head_job.up;
			mid_sel  = head_job.mid;
			down_sel = head_job.down;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.next_row_cells <= next_gen(up_sel & col_mask, mid_sel & col_mask,
				down_sel & col_mask) & col_mask;
			res_q.last_of_board  <= sel_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= !done_entry;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

### hdl/life_generation_row_stencil.sv
// top level: one Conway life generation (B3/S23, dead border) over a row stream
//
// rows of the board arrive one per request on the row channel, bit k being
// column k; last_row marks the final row. each row after the first returns
// the next generation of the row before it on the res channel; the last row
// also returns its own next generation with last_of_board set, and the line
// stores clear for the next board.
// a result goes through the job queue and the result register to res_valid.
// throughput: one row per cycle while the queue has room; a last row with rows
// before it yields two output rows, computed one per cycle when not stalled.
// a two-entry queue sits between the row front end and the back end, and the
// result register lets a new row enter while a result waits; when res_ready
// stays low the queue fills and row_ready drops after two more jobs.
// cfg_we writes board_width (columns in use, saturating at MAX_COLS); bits at
// or above it are dead on input and zero on output. write it only while idle.
// reset clears the line stores, empties the queue and the result register and sets
// board_width to 32.
module life_generation_row_stencil
	import lgrs_pkg::*;
#(
	parameter int MAX_COLS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_valid,
	output logic               row_ready,
	input  in_t                row_data,
	output logic               res_valid,
	input  logic               res_ready,
	output out_t               res_data,
	input  logic               cfg_we,
	input  logic [WIDTH_W-1:0] cfg_wdata
);

	logic [WIDTH_W-1:0] board_width_q;
	logic [WIDTH_W-1:0] width_eff;
	row_t               col_mask;
	logic               push;
	job_t               push_job;
	logic               push_ready;
	logic               pop;
	logic               head_valid;
	job_t               head_job;
	logic               held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_width_q <= BOARD_WIDTH_RESET;
		end else if (cfg_we) begin
			board_width_q <= cfg_wdata;
		end
	end

	assign width_eff = (board_width_q > WIDTH_W'(MAX_COLS)) ? WIDTH_W'(MAX_COLS)
		: board_width_q;

	always_comb begin
		for (int k = 0; k < COLS; k++) begin
			col_mask[k] = (WIDTH_W'(k) < width_eff);
		end
	end

	lgrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_valid  (row_valid),
		.row_ready  (row_ready),
		.row_data   (row_data),
		.col_mask   (col_mask),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.held       (held)
	);

	lgrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lgrs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.col_mask   (col_mask),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	a_res_masked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_data.next_row_cells & ~col_mask) == '0))
		else $error("result has bits beyond board width");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && row_ready && row_data.last_row) |=> !held)
		else $error("line stores not cleared after last row");

	a_first_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && row_ready && !row_data.last_row) |=> held)
		else $error("row not held after non-last row");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (board_width_q == $past(cfg_wdata)))
		else $error("board width write lost");

endmodule

### tb/life_generation_row_stencil_checker.sv
// checker for the life row stencil: predicts next-generation rows and compares results
module life_generation_row_stencil_checker
	import lgrs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_valid,
	input  logic               row_ready,
	input  in_t                row_data,
	input  logic               res_valid,
	input  logic               res_ready,
	input  out_t               res_data,
	input  logic               cfg_we,
	input  logic [WIDTH_W-1:0] cfg_wdata,
	output int                 errors,
	output int                 pending
);

	logic [WIDTH_W-1:0] board_cols;
	row_t               above_cells;
	row_t               middle_cells;
	logic [1:0]         rows_in_store;
	out_t               expected_rows[$];

	function automatic row_t cols_mask(input logic [WIDTH_W-1:0] cols);
		int n;
		n = (cols > 64) ? 64 : int'(cols);
		if (n >= 64)
			return '1;
		return (row_t'(1) << n) - row_t'(1);
	endfunction

	function automatic row_t life_next(input row_t up, input row_t mid, input row_t down,
		input row_t mask);
		int   n;
		int   j;
		row_t res;
		res = '0;
		up &= mask;
		mid &= mask;
		down &= mask;
		for (int k = 0; k < 64; k++) begin
			n = 0;
			for (int dk = -1; dk <= 1; dk++) begin
				j = k + dk;
				if (j >= 0 && j < 64) begin
					n += int'(up[j]) + int'(down[j]);
					if (dk != 0)
						n += int'(mid[j]);
				end
			end
			res[k] = mid[k] ? (n == 2 || n == 3) : (n == 3);
		end
		return res & mask;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		row_t mask;
		row_t cells;
		out_t want;
		if (!arst_n) begin
			board_cols = BOARD_WIDTH_RESET;
			above_cells = '0;
			middle_cells = '0;
			rows_in_store = '0;
			expected_rows.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				board_cols = cfg_wdata;
			mask = cols_mask(board_cols);

			if (res_valid && res_ready) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h last %b",
						$time, res_data.next_row_cells, res_data.last_of_board);
					errors++;
				end else begin
					want = expected_rows.pop_front();
					if (res_data.next_row_cells !== want.next_row_cells) begin
						$display("%0t: next_row_cells expected %h actual %h",
							$time, want.next_row_cells, res_data.next_row_cells);
						errors++;
					end
					if (res_data.last_of_board !== want.last_of_board) begin
						$display("%0t: last_of_board expected %b actual %b",
							$time, want.last_of_board, res_data.last_of_board);
						errors++;
					end
				end
			end

			if (row_valid && row_ready) begin
				cells = row_data.row_cells & mask;
				if (rows_in_store != 0) begin
					expected_rows.push_back({life_next(above_cells, middle_cells, cells, mask),
						1'b0});
					above_cells = middle_cells;
					middle_cells = cells;
					rows_in_store = 2'd2;
				end else begin
					above_cells = '0;
					middle_cells = cells;
					rows_in_store = 2'd1;
				end
				if (row_data.last_row) begin
					expected_rows.push_back({life_next(above_cells, middle_cells, '0, mask),
						1'b1});
					above_cells = '0;
					middle_cells = '0;
					rows_in_store = '0;
				end
			end
			pending = expected_rows.size();
		end
	end

endmodule

### tb/life_generation_row_stencil_test.sv
// testbench top for the life row stencil: clock, reset, row and config stimulus, verdict
module life_generation_row_stencil_test
	import lgrs_pkg::*;
();

	logic               clk;
	logic               arst_n;
	logic               row_valid;
	logic               row_ready;
	in_t                row_data;
	logic               res_valid;
	logic               res_ready;
	out_t               res_data;
	logic               cfg_we;
	logic [WIDTH_W-1:0] cfg_wdata;
	int                 errors;
	int                 pending;

	int   send_idle;
	int   recv_idle;
	logic hold_results;
	logic hold_done;

	life_generation_row_stencil DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_ready (row_ready),
		.row_data  (row_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	life_generation_row_stencil_checker rows_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_ready (row_ready),
		.row_data  (row_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random ready, or a long hold-off on request
	initial begin
		res_ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results && !hold_done) begin
				res_ready <= 1'b0;
				repeat (40) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_row(input row_t cells, input logic last);
		if ($urandom_range(99) < send_idle) begin
			row_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		row_valid <= 1'b1;
		row_data <= {cells, last};
		do @(posedge clk); while (!row_ready);
	endtask

	// stop sending until every result is back and the back end has settled
	task automatic drain();
		row_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_width(input logic [WIDTH_W-1:0] cols);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic row_t random_cells();
		row_t a;
		row_t b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(7))
			0: return a & b;
			1: return a | b;
			2: return a & b & {$urandom, $urandom};
			3: return '1;
			4: return '0;
			default: return a;
		endcase
	endfunction

	function automatic logic [WIDTH_W-1:0] random_width();
		case ($urandom_range(5))
			0: return 7'd64;
			1: return 7'($urandom_range(1));
			2: return 7'($urandom_range(127, 65));
			default: return 7'($urandom_range(63, 2));
		endcase
	endfunction

	task automatic random_boards(input int rows_wanted);
		int rows_sent;
		int board_rows;
		rows_sent = 0;
		while (rows_sent < rows_wanted) begin
			if ($urandom_range(3) == 0)
				write_width(random_width());
			board_rows = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(6, 1);
			for (int r = 0; r < board_rows; r++)
				send_row(random_cells(), r == board_rows - 1);
			rows_sent += board_rows;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		row_valid = 1'b0;
		row_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_results = 1'b0;
		send_idle = 36;
		recv_idle = 52;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-row board at the reset width
		send_row('1, 1'b1);

		write_width(7'd64);
		send_row('1, 1'b0);
		send_row('0, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b1);

		// no columns in use
		write_width(7'd0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);

		write_width(7'd1);
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);

		// widths above the column count saturate
		write_width(7'd127);
		send_row(64'hE000_0000_0000_0007, 1'b0);
		send_row(64'hA000_0000_0000_0005, 1'b1);
		write_width(7'd65);
		send_row('1, 1'b1);

		// blinker
		write_width(7'd5);
		send_row(64'h0, 1'b0);
		send_row(64'h4, 1'b0);
		send_row(64'h4, 1'b0);
		send_row(64'h4, 1'b0);
		send_row(64'h0, 1'b1);

		// width changed while rows are held
		write_width(7'd64);
		send_row(64'hFFFF_0000_FFFF_0000, 1'b0);
		write_width(7'd10);
		send_row('1, 1'b0);
		send_row(64'h155, 1'b1);

		write_width(7'd3);
		send_row(64'h7, 1'b1);

		random_boards(134);
		drain();

		send_idle = 52;
		recv_idle = 36;
		random_boards(133);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_width(7'd64);
		hold_results = 1'b1;
		for (int r = 0; r < 12; r++)
			send_row(random_cells(), r == 11);
		random_boards(133);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
